@@ rtl/daw_pkg.sv @@
// shared types and constants of the deletion ambiguity window block
// no dependencies
package daw_pkg;

  localparam int unsigned PosW            = 13;
  localparam int unsigned CharW           = 8;
  localparam int unsigned LoadAddrW       = 12;
  localparam int unsigned RefDepthDefault = 4096;

  typedef logic [PosW-1:0]      pos_t;
  typedef logic [CharW-1:0]     char_t;
  typedef logic [LoadAddrW-1:0] load_addr_t;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

endpackage

@@ rtl/daw_if.sv @@
// input and result channel interfaces, valid/ready handshake
// depends on daw_pkg
interface daw_in_if;
  logic               valid;
  logic               ready;
  daw_pkg::opcode_e   opcode;
  daw_pkg::load_addr_t load_address;
  daw_pkg::char_t     load_char;
  daw_pkg::pos_t      del_start;
  daw_pkg::pos_t      del_end;

  modport source (output valid, opcode, load_address, load_char, del_start, del_end,
                  input ready);
  modport sink   (input valid, opcode, load_address, load_char, del_start, del_end,
                  output ready);
endinterface

interface daw_out_if;
  logic          valid;
  logic          ready;
  daw_pkg::pos_t window_start;
  daw_pkg::pos_t window_end;

  modport source (output valid, window_start, window_end, input ready);
  modport sink   (input valid, window_start, window_end, output ready);
endinterface

@@ rtl/daw_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module daw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/deletion_ambiguity_window.sv @@
// query: the start search runs first, then the end search, each step a fetch of the flanking
//   base and a scan of the window; the single ram read port sets the pace, and a stalled
//   result holds the block in ST_DONE
// throughput: one load transaction per cycle while no query is in progress; one query at a time
// reset: control state and ref_length clear at once; the reference store is not cleared
//   and needs no clearing pass, so items are taken right after reset
// depends on daw_pkg, daw_if, daw_ram
module deletion_ambiguity_window #(
  parameter int unsigned REF_DEPTH = daw_pkg::RefDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  daw_in_if.sink        in_ch,
  daw_out_if.source     out_ch,
  input  logic          cfg_we_i,
  input  daw_pkg::pos_t cfg_wdata_i
);
  import daw_pkg::*;

  localparam int unsigned AW = $clog2(REF_DEPTH);

  // one-hot sequencer: start search steps, then end search steps
  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_S_FETCH = 8'b0000_0010,  // read the base before the window
    ST_S_CHAR  = 8'b0000_0100,  // capture it, issue first scan read
    ST_S_SCAN  = 8'b0000_1000,  // downward scan of the window
    ST_E_FETCH = 8'b0001_0000,  // read the base after the window
    ST_E_CHAR  = 8'b0010_0000,
    ST_E_SCAN  = 8'b0100_0000,  // upward scan of the window
    ST_DONE    = 8'b1000_0000   // hand result to the output register
  } state_e;

  state_e state_q, state_d;

  pos_t  ref_length_q;
  pos_t  s_q, s_d, e_q, e_d;          // queried window
  pos_t  m_q, m_d, n_q, n_d;          // working window [m, n)
  pos_t  p_q, p_d;                    // scan issue pointer
  pos_t  pend_pos_q, pend_pos_d;      // position of the read in flight
  logic  pend_q, pend_d;              // a scan read is in flight
  char_t c_q, c_d;                    // base being matched
  pos_t  wstart_q, wstart_d;
  logic  oob_q;                       // last read was beyond the store

  logic  out_valid_q, out_valid_d;
  pos_t  out_start_q, out_start_d, out_end_q, out_end_d;

  // ram ports
  logic          ram_we, rd_en;
  logic [AW-1:0] ram_waddr, ram_raddr;
  char_t         ram_rdata, rdata_eff;
  pos_t          rd_pos;
  logic [31:0]   rd_pos_ext, wa_ext;

  logic in_acc;
  logic start_phase, issue_left, hit;
  pos_t scan_addr;

  // ---------------------------------------------------------------------------
  // input handshake and loads
  // ---------------------------------------------------------------------------
  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // loads beyond the store are dropped
  assign wa_ext    = 32'(in_ch.load_address);
  assign ram_waddr = wa_ext[AW-1:0];
  assign ram_we    = in_acc && (in_ch.opcode == OP_LOAD) && (wa_ext < REF_DEPTH);

  assign rd_pos_ext = 32'(rd_pos);
  assign ram_raddr  = rd_pos_ext[AW-1:0];

  daw_ram #(
    .WIDTH (CharW),
    .DEPTH (REF_DEPTH)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_ch.load_char),
    .re_i    (rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // positions past the store read as zero
  always_ff @(posedge clk_i) begin
    oob_q <= (rd_pos_ext >= REF_DEPTH);
  end
  assign rdata_eff = oob_q ? '0 : ram_rdata;

  // ---------------------------------------------------------------------------
  // scan helpers: start search scans [m, n) downward, end search upward
  // ---------------------------------------------------------------------------
  assign start_phase = (state_q == ST_S_CHAR) || (state_q == ST_S_SCAN);
  assign issue_left  = start_phase ? (p_q > m_q) : (p_q < n_q);
  assign scan_addr   = start_phase ? (p_q - 1'b1) : p_q;
  assign hit         = pend_q && (rdata_eff == c_q);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    s_d         = s_q;
    e_d         = e_q;
    m_d         = m_q;
    n_d         = n_q;
    p_d         = p_q;
    pend_d      = 1'b0;
    pend_pos_d  = pend_pos_q;
    c_d         = c_q;
    wstart_d    = wstart_q;
    rd_en       = 1'b0;
    rd_pos      = scan_addr;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_start_d = out_start_q;
    out_end_d   = out_end_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_ch.opcode == OP_QUERY)) begin
          s_d     = in_ch.del_start;
          e_d     = in_ch.del_end;
          m_d     = in_ch.del_start;
          n_d     = in_ch.del_end;
          state_d = ST_S_FETCH;
        end
      end

      ST_S_FETCH: begin
        if (m_q == '0) begin
          // start search reached position zero
          wstart_d = m_q;
          m_d      = s_q;
          n_d      = e_q;
          state_d  = ST_E_FETCH;
        end else begin
          rd_en   = 1'b1;
          rd_pos  = m_q - 1'b1;
          p_d     = n_q;
          state_d = ST_S_CHAR;
        end
      end

      ST_S_CHAR, ST_E_CHAR: begin
        c_d = rdata_eff;
        if (issue_left) begin
          rd_en      = 1'b1;
          pend_d     = 1'b1;
          pend_pos_d = scan_addr;
          p_d        = start_phase ? (p_q - 1'b1) : (p_q + 1'b1);
        end
        state_d = (state_q == ST_S_CHAR) ? ST_S_SCAN : ST_E_SCAN;
      end

      ST_S_SCAN: begin
        if (hit) begin
          // last occurrence below n: window slides left by one
          n_d     = pend_pos_q;
          m_d     = m_q - 1'b1;
          state_d = ST_S_FETCH;
        end else if (issue_left) begin
          rd_en      = 1'b1;
          pend_d     = 1'b1;
          pend_pos_d = scan_addr;
          p_d        = p_q - 1'b1;
        end else begin
          wstart_d = m_q;
          m_d      = s_q;
          n_d      = e_q;
          state_d  = ST_E_FETCH;
        end
      end

      ST_E_FETCH: begin
        if (n_q >= ref_length_q) begin
          state_d = ST_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_pos  = n_q;
          p_d     = m_q;
          state_d = ST_E_CHAR;
        end
      end

      ST_E_SCAN: begin
        if (hit) begin
          // first occurrence: m moves past it, n grows by one
          m_d     = pend_pos_q + 1'b1;
          n_d     = n_q + 1'b1;
          state_d = ST_E_FETCH;
        end else if (issue_left) begin
          rd_en      = 1'b1;
          pend_d     = 1'b1;
          pend_pos_d = scan_addr;
          p_d        = p_q + 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d = 1'b1;
          out_start_d = wstart_q;
          out_end_d   = n_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      ref_length_q <= '0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        ref_length_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    s_q         <= s_d;
    e_q         <= e_d;
    m_q         <= m_d;
    n_q         <= n_d;
    p_q         <= p_d;
    pend_pos_q  <= pend_pos_d;
    c_q         <= c_d;
    wstart_q    <= wstart_d;
    out_start_q <= out_start_d;
    out_end_q   <= out_end_d;
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.window_start = out_start_q;
  assign out_ch.window_end   = out_end_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // loads and searches never share the ram in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) ram_we |-> !rd_en)
    else $error("ram write and read in the same cycle");

  // a scan read in flight is only seen by a scan state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_S_SCAN || state_q == ST_E_SCAN))
    else $error("scan read in flight outside a scan state");

  // the window only widens
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (wstart_q <= s_q && n_q >= e_q))
    else $error("result window narrower than the query");

endmodule

@@ tb/deletion_ambiguity_window_tb.sv @@
// self-checking testbench of deletion_ambiguity_window: reference loads, window queries,
// ref_length writes, a scoreboard class that predicts each ambiguity window and checks it
// depends on daw_pkg, daw_in_if, daw_out_if and the block itself
module deletion_ambiguity_window_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import daw_pkg::*;

  localparam int unsigned REF_DEPTH     = RefDepthDefault;
  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned CYCLE_LIMIT   = 10_000_000;
  // queries that would scan longer than this are not sent, keeps the run short
  localparam int unsigned READ_BUDGET   = 600;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned PHASE_ITEMS   = 310;

  // small alphabet for tandem repeats, one byte per letter
  localparam logic [31:0] REPEAT_BASES = {8'h54, 8'h47, 8'h43, 8'h41};
  // directed reference, position 0 in the low byte: 00 A C A C A C 7E G G G FF
  localparam logic [95:0] DIRECTED_REF = {8'hFF, 8'h47, 8'h47, 8'h47, 8'h7E, 8'h43,
                                          8'h41, 8'h43, 8'h41, 8'h43, 8'h41, 8'h00};

  typedef struct {
    opcode_e    opcode;
    load_addr_t addr;
    char_t      ch;
    pos_t       del_start;
    pos_t       del_end;
  } ref_op_t;

  typedef struct {
    pos_t win_start;
    pos_t win_end;
  } window_t;

  // mirror of the reference store plus the queue of windows still owed by the block
  class ambiguity_scoreboard;
    char_t       ref_copy [REF_DEPTH];
    bit          written  [REF_DEPTH];
    int unsigned ref_len;
    window_t     pending_windows [$];
    int unsigned failures;
    int unsigned reads;
    bit          touched_unwritten;
    bit          over_budget;

    function void set_ref_length(int unsigned value);
      ref_len = value;
    endfunction

    // positions past the store read as zero
    function int unsigned read_base(int unsigned pos);
      reads++;
      if (pos >= REF_DEPTH) return 0;
      if (!written[load_addr_t'(pos)]) touched_unwritten = 1'b1;
      return 32'(ref_copy[load_addr_t'(pos)]);
    endfunction

    function window_t ambiguity_window(pos_t del_start, pos_t del_end);
      window_t     w;
      int unsigned m, n, i, c;
      bit          hit;
      reads             = 0;
      touched_unwritten = 1'b0;
      over_budget       = 1'b0;
      // 5-prime shift: last occurrence of the base before m inside [m, n)
      m = 32'(del_start);
      n = 32'(del_end);
      while (m > 0 && !over_budget) begin
        c   = read_base(m - 1);
        hit = 1'b0;
        i   = n;
        while (i > m && !hit) begin
          i--;
          hit = (read_base(i) == c);
        end
        if (!hit) break;
        n = i;
        m--;
        over_budget = (reads > READ_BUDGET);
      end
      w.win_start = pos_t'(m);
      // 3-prime shift: first occurrence of the base at n inside [m, n)
      m = 32'(del_start);
      n = 32'(del_end);
      while (n < ref_len && !over_budget) begin
        c   = read_base(n);
        hit = 1'b0;
        i   = m;
        while (i < n && !hit) begin
          hit = (read_base(i) == c);
          if (!hit) i++;
        end
        if (!hit) break;
        m = i + 1;
        n++;
        over_budget = (reads > READ_BUDGET);
      end
      w.win_end = pos_t'(n);
      return w;
    endfunction

    function bit query_is_safe(pos_t del_start, pos_t del_end);
      void'(ambiguity_window(del_start, del_end));
      return !touched_unwritten && !over_budget && (reads <= READ_BUDGET);
    endfunction

    function void note_transaction(ref_op_t op);
      if (op.opcode == OP_LOAD) begin
        if (op.addr < REF_DEPTH) begin
          ref_copy[op.addr] = op.ch;
          written[op.addr]  = 1'b1;
        end
      end else begin
        pending_windows.push_back(ambiguity_window(op.del_start, op.del_end));
      end
    endfunction

    function void check_window(pos_t got_start, pos_t got_end);
      window_t want;
      if (pending_windows.size() == 0) begin
        $error("window_start/window_end: expected no transaction, actual %0d/%0d",
               got_start, got_end);
        failures++;
        return;
      end
      want = pending_windows.pop_front();
      if (got_start !== want.win_start) begin
        $error("window_start: expected %0d, actual %0d", want.win_start, got_start);
        failures++;
      end
      if (got_end !== want.win_end) begin
        $error("window_end: expected %0d, actual %0d", want.win_end, got_end);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  pos_t        cfg_wdata_i;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned phase_items    = 0;

  ambiguity_scoreboard sb = new;

  daw_in_if  in_ch ();
  daw_out_if out_ch ();

  deletion_ambiguity_window #(
    .REF_DEPTH(REF_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // result side back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // every accepted result transaction goes straight to the checker
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_window(out_ch.window_start, out_ch.window_end);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // entered and left at a falling edge; valid stays high when the next call sends at once
  task automatic send_op(ref_op_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op.opcode;
    in_ch.load_address <= op.addr;
    in_ch.load_char    <= op.ch;
    in_ch.del_start    <= op.del_start;
    in_ch.del_end      <= op.del_end;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_transaction(op);
    phase_items++;
    @(negedge clk_i);
  endtask

  // query fields carry noise on a load, the block must ignore them
  task automatic load_base(int unsigned addr, char_t ch);
    ref_op_t op;
    op.opcode    = OP_LOAD;
    op.addr      = load_addr_t'(addr);
    op.ch        = ch;
    op.del_start = pos_t'($urandom_range(REF_DEPTH));
    op.del_end   = pos_t'($urandom_range(REF_DEPTH));
    send_op(op);
  endtask

  task automatic query_window(int unsigned del_start, int unsigned del_end);
    ref_op_t op;
    op.opcode    = OP_QUERY;
    op.addr      = load_addr_t'($urandom);
    op.ch        = char_t'($urandom);
    op.del_start = pos_t'(del_start);
    op.del_end   = pos_t'(del_end);
    send_op(op);
  endtask

  // drain all queries, then give a trailing load time to land
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending_windows.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_ref_length(int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= pos_t'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_ref_length(value);
  endtask

  // reference text: tandem repeats of short units between random single bytes
  task automatic load_region(int unsigned lo, int unsigned top);
    int unsigned pos;
    int unsigned unit_len;
    int unsigned reps;
    int unsigned k;
    char_t       unit [4];
    pos = lo;
    while (pos < top) begin
      if ($urandom_range(1) == 1) begin
        unit_len = $urandom_range(1, 4);
        reps     = $urandom_range(2, 4);
        for (k = 0; k < unit_len; k++) begin
          unit[2'(k)] = REPEAT_BASES[8 * $urandom_range(3) +: 8];
        end
        for (k = 0; k < unit_len * reps && pos < top; k++) begin
          load_base(pos, unit[2'(k % unit_len)]);
          pos++;
        end
      end else begin
        load_base(pos, char_t'($urandom_range(255)));
        pos++;
      end
    end
  endtask

  // one reference setting: load text, set ref_length, then a burst of queries
  task automatic run_block();
    int unsigned lo, top, len, n_ops, k, tries, s, e, r;
    bit          sent;
    if ($urandom_range(5) == 0) begin
      // text hugging the top of the store, whole store valid
      len = REF_DEPTH;
      lo  = REF_DEPTH - $urandom_range(32, 96);
      top = REF_DEPTH;
    end else begin
      // short text at the bottom, some written bases past ref_length
      len = $urandom_range(16, 64);
      lo  = 0;
      top = len + $urandom_range(0, 16);
    end
    load_region(lo, top);
    settle();
    write_ref_length(len);
    n_ops = $urandom_range(30, 60);
    for (k = 0; k < n_ops; k++) begin
      if ($urandom_range(9) == 0) begin
        // noise: rewrite a base inside the text or anywhere in the store
        if ($urandom_range(1) == 1) begin
          load_base($urandom_range(lo, top - 1), REPEAT_BASES[8 * $urandom_range(3) +: 8]);
        end else begin
          load_base($urandom_range(REF_DEPTH - 1), char_t'($urandom_range(255)));
        end
      end else begin
        sent = 1'b0;
        for (tries = 0; tries < 8 && !sent; tries++) begin
          r = $urandom_range(99);
          if (r < 65) begin
            // short deletion somewhere in the text
            s = $urandom_range(lo, top);
            e = s + $urandom_range(0, 6);
            if (e > top) e = top;
          end else if (r < 78) begin
            // start after end
            s = $urandom_range(lo + 1, top);
            e = $urandom_range(lo, s - 1);
          end else if (r < 90) begin
            // long window
            s = $urandom_range(lo, top);
            e = $urandom_range(s, top);
          end else begin
            s = $urandom_range(REF_DEPTH);
            e = $urandom_range(REF_DEPTH);
          end
          // only queries that touch written bases and stay short
          if (sb.query_is_safe(pos_t'(s), pos_t'(e))) begin
            query_window(s, e);
            sent = 1'b1;
          end
        end
        if (!sent) load_base($urandom_range(lo, top - 1), char_t'($urandom_range(255)));
      end
    end
  endtask

  task automatic run_phase(int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    phase_items    = 0;
    while (phase_items < PHASE_ITEMS) run_block();
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_LOAD;
    in_ch.load_address = '0;
    in_ch.load_char    = '0;
    in_ch.del_start    = '0;
    in_ch.del_end      = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty reference, no search can move
    write_ref_length(0);
    query_window(0, 0);
    query_window(0, REF_DEPTH);

    // directed: small text with repeats plus both ends of the store
    for (int k = 0; k < 12; k++) load_base(k, DIRECTED_REF[8 * k +: 8]);
    load_base(REF_DEPTH - 2, 8'h00);
    load_base(REF_DEPTH - 1, 8'hFF);
    settle();
    write_ref_length(12);
    query_window(3, 5);    // dinucleotide repeat, moves both ways
    query_window(8, 9);    // homopolymer run
    query_window(0, 1);    // start at zero
    query_window(10, 12);  // end at ref_length
    query_window(6, 4);    // start after end
    query_window(7, 8);    // unique base, nothing moves

    // directed: whole store valid, windows at the very top
    settle();
    write_ref_length(REF_DEPTH);
    query_window(REF_DEPTH, REF_DEPTH);
    query_window(REF_DEPTH - 1, REF_DEPTH);

    // random traffic under each idling pattern
    run_phase(0, 0);
    run_phase(64, 0);
    run_phase(0, 64);
    run_phase(32, 32);

    in_ch.valid <= 1'b0;
    while (sb.pending_windows.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending_windows.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/daw_pkg.sv
rtl/daw_if.sv
rtl/daw_ram.sv
rtl/deletion_ambiguity_window.sv
tb/deletion_ambiguity_window_tb.sv
